// ===== sv/ffa_pkg.sv =====
package ffa_pkg;
  localparam int PoolNodes = 64;
  localparam int AddrBits = 32;
  localparam int SlotBits = $clog2(PoolNodes);
  localparam logic [AddrBits:0] AddrLimit = {1'b0, {AddrBits{1'b1}}};

  localparam logic [1:0] KIND_ALLOC  = 2'd0;
  localparam logic [1:0] KIND_FREE   = 2'd1;
  localparam logic [1:0] KIND_RESIZE = 2'd2;
  localparam logic [1:0] KIND_INIT   = 2'd3;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_NOFIT  = 2'd1;
  localparam logic [1:0] ST_NOSLOT = 2'd2;
  localparam logic [1:0] ST_NOEXT  = 2'd3;

  // configuration register indexes
  localparam logic CFG_BASE  = 1'b0;
  localparam logic CFG_BYTES = 1'b1;

  // operation the datapath carries out for the current item
  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_GIVE  = 2'd1,
    OP_EXT   = 2'd2
  } op_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch item, start at list head
    logic init;      // rebuild list from arena registers
    logic rd;        // issue node read at cur
    logic step;      // evaluate node data
    logic slot_rd;   // read in-use bit at scan index
    logic slot_adv;  // report that no free slot was found
    logic link;      // point predecessor at the fresh slot
    logic commit;    // apply decision
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic quick;     // item answered without walking
    logic stop;      // walk found its spot
    logic need_slot; // spot needs a fresh slot
    logic slot_hit;  // scan found a free slot
    logic slot_end;  // scan exhausted
    logic clr_done;  // in-use bit sweep done (reset or init)
  } stat_t;
endpackage

// ===== sv/ffa_ram.sv =====
module ffa_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/ffa_datapath.sv =====
module ffa_datapath import ffa_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output stat_t               stat,
  input  logic [1:0]          kind,
  input  logic [AddrBits-1:0] block_addr,
  input  logic [AddrBits-1:0] size,
  input  logic [AddrBits-1:0] new_size,
  input  logic [AddrBits-1:0] arena_base,
  input  logic [AddrBits-1:0] arena_bytes,
  output logic [1:0]          status,
  output logic [AddrBits-1:0] result_addr
);
  localparam int NodeW = 2 * AddrBits + SlotBits + 1;

  // node memory: {start, length, link, link_ok}
  logic                nd_we;
  logic [SlotBits-1:0] nd_waddr, nd_raddr;
  logic [NodeW-1:0]    nd_wdata, nd_rdata;
  ffa_ram #(.Width(NodeW), .Depth(PoolNodes)) u_node (
    .clk(clk), .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata),
    .raddr(nd_raddr), .rdata(nd_rdata)
  );

  // slot in-use bits live in a second memory, cleared by sweep at reset and at init
  logic                us_we, us_wdata;
  logic [SlotBits-1:0] us_waddr, us_raddr;
  logic                us_rdata;
  ffa_ram #(.Width(1), .Depth(PoolNodes)) u_used (
    .clk(clk), .we(us_we), .waddr(us_waddr), .wdata(us_wdata),
    .raddr(us_raddr), .rdata(us_rdata)
  );

  logic [AddrBits-1:0] c_start, c_len;
  logic [SlotBits-1:0] c_link;
  logic                c_lok;
  assign {c_start, c_len, c_link, c_lok} = nd_rdata;

  // list head and reset-cleared control
  logic                list_nonempty;
  logic [SlotBits-1:0] list_first;
  logic                clearing;
  logic [SlotBits:0]   clr_idx;

  // walk state
  op_t                 op;
  logic [AddrBits-1:0] g_start, g_len, need, amt;
  logic [AddrBits:0]   want;
  logic [SlotBits-1:0] cur, prev;
  logic                c_ok, p_ok;
  logic [AddrBits-1:0] p_start, p_len;
  logic [SlotBits-1:0] p_link;
  logic                p_lok;
  logic [SlotBits:0]   scan;
  logic [SlotBits-1:0] scan_q;
  logic                scan_v;
  logic                quick;
  logic [1:0]          q_status;

  // decision latched at stop
  typedef enum logic [2:0] {
    D_NONE, D_UNLINK_CUR, D_TRIM_CUR, D_GROW_PREV, D_MERGE_BOTH, D_GROW_CUR, D_INSERT
  } dec_t;
  dec_t                dec;
  logic [1:0]          dec_status;
  logic [AddrBits-1:0] dec_addr;
  logic [AddrBits-1:0] s_start, s_len;
  logic [SlotBits-1:0] s_link;
  logic                s_lok;

  logic [AddrBits:0] g_end, p_end;
  assign g_end = {1'b0, g_start} + {1'b0, g_len};
  assign p_end = {1'b0, p_start} + {1'b0, p_len};

  // evaluate the node now in c_*
  logic stop_now;
  dec_t dec_now;
  logic [1:0] dstat_now;
  logic [AddrBits-1:0] daddr_now;
  logic pa, na;
  always_comb begin
    stop_now  = 1'b0;
    dec_now   = D_NONE;
    dstat_now = ST_DONE;
    daddr_now = block_addr;
    pa = p_ok && (p_end == {1'b0, g_start});
    na = c_ok && (g_end == {1'b0, c_start});
    case (op)
      OP_ALLOC: begin
        if (!c_ok) begin
          stop_now = 1'b1; dstat_now = ST_NOFIT; daddr_now = '0;
        end else if (c_len == amt) begin
          stop_now = 1'b1; dec_now = D_UNLINK_CUR; daddr_now = c_start;
        end else if (c_len > amt) begin
          stop_now = 1'b1; dec_now = D_TRIM_CUR; daddr_now = c_start;
        end
      end
      OP_EXT: begin
        if (!c_ok || {1'b0, c_start} > want) begin
          stop_now = 1'b1; dstat_now = ST_NOEXT;
        end else if ({1'b0, c_start} == want) begin
          stop_now = 1'b1;
          if (c_len < need) dstat_now = ST_NOEXT;
          else if (c_len == need) dec_now = D_UNLINK_CUR;
          else dec_now = D_TRIM_CUR;
        end
      end
      default: begin
        if (!c_ok || c_start > g_start) begin
          stop_now = 1'b1;
          if (pa && na) dec_now = D_MERGE_BOTH;
          else if (pa) dec_now = D_GROW_PREV;
          else if (na) dec_now = D_GROW_CUR;
          else dec_now = D_INSERT;
        end
      end
    endcase
  end

  assign stat.quick     = quick;
  assign stat.stop      = stop_now;
  assign stat.need_slot = (dec == D_INSERT);
  assign stat.slot_hit  = scan_v && !us_rdata;
  assign stat.slot_end  = scan_v && us_rdata && (scan == (SlotBits+1)'(PoolNodes));
  assign stat.clr_done  = !clearing;

  // arena clip
  logic arena_ok;
  logic [AddrBits-1:0] arena_len, arena_room;
  always_comb begin
    arena_room = AddrLimit[AddrBits-1:0] - arena_base;
    arena_ok = (arena_bytes != '0) && ({1'b0, arena_base} < AddrLimit);
    arena_len = (arena_bytes > arena_room) ? arena_room : arena_bytes;
  end

  // memory addressing
  always_comb begin
    nd_raddr = cur;
    us_raddr = scan[SlotBits-1:0];
    us_we = 1'b0; us_waddr = scan_q; us_wdata = 1'b1;
    nd_we = 1'b0; nd_waddr = cur; nd_wdata = nd_rdata;
    if (clearing) begin
      us_we = 1'b1; us_waddr = clr_idx[SlotBits-1:0]; us_wdata = 1'b0;
    end else if (cmd.link) begin
      nd_we = p_ok; nd_waddr = prev;
      nd_wdata = {p_start, p_len, scan_q, 1'b1};
    end else if (cmd.commit) begin
      unique case (dec)
        D_UNLINK_CUR: begin
          us_we = 1'b1; us_waddr = cur; us_wdata = 1'b0;
          nd_we = p_ok; nd_waddr = prev;
          nd_wdata = {p_start, p_len, s_link, s_lok};
        end
        D_TRIM_CUR: begin
          nd_we = 1'b1; nd_waddr = cur;
          nd_wdata = {s_start + amt, s_len - amt, s_link, s_lok};
        end
        D_GROW_PREV: begin
          nd_we = 1'b1; nd_waddr = prev;
          nd_wdata = {p_start, p_len + g_len, p_link, p_lok};
        end
        D_MERGE_BOTH: begin
          us_we = 1'b1; us_waddr = cur; us_wdata = 1'b0;
          nd_we = 1'b1; nd_waddr = prev;
          nd_wdata = {p_start, p_len + g_len + s_len, s_link, s_lok};
        end
        D_GROW_CUR: begin
          nd_we = 1'b1; nd_waddr = cur;
          nd_wdata = {g_start, s_len + g_len, s_link, s_lok};
        end
        D_INSERT: begin
          us_we = 1'b1; us_waddr = scan_q; us_wdata = 1'b1;
          nd_we = 1'b1; nd_waddr = scan_q;
          nd_wdata = {g_start, g_len, cur, c_ok};
        end
        default: ;
      endcase
    end else if (cmd.init && arena_ok) begin
      nd_we = 1'b1; nd_waddr = '0;
      nd_wdata = {arena_base, arena_len, {SlotBits{1'b0}}, 1'b0};
      us_we = 1'b1; us_waddr = '0; us_wdata = 1'b1;
    end
  end

  logic [AddrBits:0] rz_start;
  assign rz_start = {1'b0, block_addr} + {1'b0, new_size};

  always_ff @(posedge clk) begin
    if (rst) begin
      list_nonempty <= 1'b0;
      list_first    <= '0;
      clearing      <= 1'b1;
      clr_idx       <= '0;
      scan_v        <= 1'b0;
    end else begin
      // sweep in-use bits
      if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == (SlotBits+1)'(PoolNodes - 1)) clearing <= 1'b0;
      end
      if (cmd.init) begin
        clearing <= 1'b1;
        clr_idx  <= arena_ok ? (SlotBits+1)'(1) : '0;
        list_first <= '0;
        list_nonempty <= arena_ok;
      end
      // free-slot scan
      scan_v <= cmd.slot_rd;
      if (cmd.slot_rd) begin
        scan_q <= scan[SlotBits-1:0];
        scan <= scan + 1'b1;
      end
      if (cmd.load) scan <= '0;
      // head updates on commit
      if (cmd.commit && !p_ok && (dec == D_UNLINK_CUR)) begin
        list_first <= s_link; list_nonempty <= s_lok;
      end
      if (cmd.commit && !p_ok && (dec == D_INSERT)) begin
        list_first <= scan_q; list_nonempty <= 1'b1;
      end
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= list_first;
      c_ok <= list_nonempty;
      p_ok <= 1'b0;
      prev <= '0;
      quick <= 1'b0;
      q_status <= ST_DONE;
      amt <= size;
      want <= {1'b0, block_addr} + {1'b0, size};
      need <= new_size - size;
      g_start <= block_addr;
      g_len <= size;
      op <= OP_ALLOC;
      unique case (kind)
        KIND_ALLOC: op <= OP_ALLOC;
        KIND_FREE: begin
          op <= OP_GIVE;
          if (size == '0) quick <= 1'b1;
          else if ({1'b0, size} > AddrLimit - {1'b0, block_addr}) begin
            quick <= 1'b1; q_status <= ST_NOFIT;
          end
        end
        KIND_RESIZE: begin
          if (new_size < size) begin
            op <= OP_GIVE;
            g_start <= rz_start[AddrBits-1:0];
            g_len <= size - new_size;
            if (rz_start > AddrLimit ||
                {1'b0, size - new_size} > AddrLimit - rz_start) begin
              quick <= 1'b1; q_status <= ST_NOFIT;
            end
          end else if (new_size > size) begin
            op <= OP_EXT;
            amt <= new_size - size;
          end else quick <= 1'b1;
        end
        default: quick <= 1'b1;
      endcase
      result_addr <= (kind == KIND_INIT) ? arena_base : block_addr;
      status <= ST_DONE;
    end
    if (cmd.step) begin
      if (stop_now) begin
        dec <= dec_now;
        dec_status <= dstat_now;
        dec_addr <= daddr_now;
        s_start <= c_start; s_len <= c_len; s_link <= c_link; s_lok <= c_lok;
      end else begin
        prev <= cur; p_ok <= 1'b1;
        p_start <= c_start; p_len <= c_len; p_link <= c_link; p_lok <= c_lok;
        cur <= c_link; c_ok <= c_lok;
      end
    end
    if (cmd.commit) begin
      status <= quick ? q_status : dec_status;
      if (!quick && op == OP_ALLOC) result_addr <= dec_addr;
    end
    if (cmd.slot_adv) begin
      status <= ST_NOSLOT;
    end
    if (cmd.load) dec <= D_NONE;
    if (cmd.commit && quick) dec <= D_NONE;
  end
endmodule

// ===== sv/ffa_ctrl.sv =====
module ffa_ctrl import ffa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_fire,
  input  logic  in_init,
  input  logic  out_free,
  output logic  busy,
  output logic  done,
  output cmd_t  cmd,
  input  stat_t stat
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_START = 8'b0000_0010,
    S_RD    = 8'b0000_0100,
    S_EVAL  = 8'b0000_1000,
    S_SLOT  = 8'b0001_0000,
    S_SWAIT = 8'b0010_0000,
    S_COMM  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;
  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    done = 1'b0;
    unique case (state)
      S_IDLE: if (in_fire) begin
        cmd.load = 1'b1;
        cmd.init = in_init;
        state_next = in_init ? S_OUT : S_START;
      end
      S_START: state_next = stat.quick ? S_COMM : S_RD;
      S_RD: state_next = S_EVAL;
      S_EVAL: begin
        cmd.step = 1'b1;
        state_next = stat.stop ? S_SLOT : S_RD;
      end
      S_SLOT: begin
        if (stat.need_slot) begin
          cmd.slot_rd = 1'b1;
          state_next = S_SWAIT;
        end else state_next = S_COMM;
      end
      S_SWAIT: begin
        if (stat.slot_hit) begin
          cmd.link = 1'b1;
          state_next = S_COMM;
        end else if (stat.slot_end) begin
          cmd.slot_adv = 1'b1;
          state_next = S_OUT;
        end else cmd.slot_rd = 1'b1;
      end
      S_COMM: begin
        cmd.commit = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        done = stat.clr_done;
        if (stat.clr_done && out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE) || !stat.clr_done;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule

// ===== sv/first_fit_free_extent_allocator.sv =====
// channel   dir  tdata fields (low bit up)                 tuser
// s_axis    in   block_addr[31:0] size new_size             kind[1:0]
// m_axis    out  result_addr[31:0]                          status[1:0]
// cfg       in   we, index (0 arena_base, 1 arena_bytes), wdata[31:0]
// An item walks the free list one node at a time, a read state then an evaluate
// state per node (one memory read port); a quick item skips the walk.
// A free or shrinking resize needing a fresh slot scans up to 64 in-use bits for one.
// Reset sweeps all 64 in-use bits; an init sweeps 63 of them (slot 0 holds the arena),
// or all 64 with an empty arena, before its result. No item is taken meanwhile.
// A waiting result holds until taken; the next item is taken after that.
module first_fit_free_extent_allocator import ffa_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,  // block_addr, size, new_size
  input  logic [1:0]   s_axis_tuser,  // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata,  // result_addr
  output logic [1:0]   m_axis_tuser,  // status
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_wdata
);
  logic [31:0] arena_base, arena_bytes;
  cmd_t  cmd;
  stat_t stat;
  logic  busy, done, in_fire;

  // hold arena registers
  always_ff @(posedge clk) begin
    if (rst) begin
      arena_base <= '0; arena_bytes <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_BASE) arena_base <= cfg_wdata;
      else arena_bytes <= cfg_wdata;
    end
  end

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = done;

  ffa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire),
    .in_init(s_axis_tuser == KIND_INIT), .out_free(m_axis_tready),
    .busy(busy), .done(done), .cmd(cmd), .stat(stat)
  );

  ffa_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .kind(s_axis_tuser), .block_addr(s_axis_tdata[31:0]),
    .size(s_axis_tdata[63:32]), .new_size(s_axis_tdata[95:64]),
    .arena_base(arena_base), .arena_bytes(arena_bytes),
    .status(m_axis_tuser), .result_addr(m_axis_tdata)
  );

  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("item accepted with result pending");
  a_result_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !m_axis_tvalid || $past(s_axis_tuser) == KIND_INIT)
    else $error("result too early");
endmodule

// ===== test/tb_first_fit_free_extent_allocator.sv =====
module tb_first_fit_free_extent_allocator;
  import ffa_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;   // block_addr, size, new_size
  logic [1:0]  s_axis_tuser = '0;   // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // result_addr
  logic [1:0]  m_axis_tuser;        // status
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_wdata = '0;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] addr;
  } reply_t;

  first_fit_free_extent_allocator i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow free list, kept in address order
  logic [32:0] fl_start[$];
  logic [32:0] fl_len[$];
  logic [32:0] base_q, bytes_q;
  reply_t      replies_due[$];
  int          errors = 0;
  int          send_idle = 0;
  int          recv_idle = 0;

  // extent records are 33-bit to keep the end exact
  function automatic logic [1:0] model_release(logic [32:0] st, logic [32:0] ln);
    int  i;
    bit  pa, na;
    if (ln == 0) return ST_DONE;
    if (st > AddrLimit || ln > AddrLimit - st) return ST_NOFIT;
    i = 0;
    while (i < fl_start.size() && fl_start[i] <= st) i++;
    pa = i > 0 && fl_start[i-1] + fl_len[i-1] == st;
    na = i < fl_start.size() && st + ln == fl_start[i];
    if (pa && na) begin
      fl_len[i-1] = fl_len[i-1] + ln + fl_len[i];
      fl_start.delete(i);
      fl_len.delete(i);
    end else if (pa) begin
      fl_len[i-1] = fl_len[i-1] + ln;
    end else if (na) begin
      fl_start[i] = st;
      fl_len[i] = fl_len[i] + ln;
    end else begin
      if (fl_start.size() >= PoolNodes) return ST_NOSLOT;
      fl_start.insert(i, st);
      fl_len.insert(i, ln);
    end
    return ST_DONE;
  endfunction

  function automatic reply_t predict_reply(logic [1:0] kind, logic [31:0] blk,
                                           logic [31:0] sz, logic [31:0] nsz);
    reply_t      r;
    logic [32:0] want, need, ln;
    r.status = ST_DONE;
    r.addr = blk;
    case (kind)
      KIND_ALLOC: begin
        r.status = ST_NOFIT;
        r.addr = '0;
        for (int i = 0; i < fl_start.size(); i++) begin
          if (fl_len[i] >= {1'b0, sz}) begin
            r.status = ST_DONE;
            r.addr = fl_start[i][31:0];
            if (fl_len[i] == {1'b0, sz}) begin
              fl_start.delete(i);
              fl_len.delete(i);
            end else begin
              fl_start[i] = fl_start[i] + sz;
              fl_len[i] = fl_len[i] - sz;
            end
            break;
          end
        end
      end
      KIND_FREE: r.status = model_release({1'b0, blk}, {1'b0, sz});
      KIND_RESIZE: begin
        if (nsz < sz) begin
          r.status = model_release({1'b0, blk} + nsz, {1'b0, sz - nsz});
        end else if (nsz > sz) begin
          want = {1'b0, blk} + sz;
          need = {1'b0, nsz - sz};
          r.status = ST_NOEXT;
          for (int i = 0; i < fl_start.size(); i++) begin
            if (fl_start[i] > want) break;
            if (fl_start[i] == want) begin
              if (fl_len[i] >= need) begin
                r.status = ST_DONE;
                if (fl_len[i] == need) begin
                  fl_start.delete(i);
                  fl_len.delete(i);
                end else begin
                  fl_start[i] = fl_start[i] + need;
                  fl_len[i] = fl_len[i] - need;
                end
              end
              break;
            end
          end
        end
      end
      default: begin
        fl_start.delete();
        fl_len.delete();
        r.addr = base_q[31:0];
        if (bytes_q != 0 && base_q < AddrLimit) begin
          ln = bytes_q;
          if (ln > AddrLimit - base_q) ln = AddrLimit - base_q;
          fl_start.push_back(base_q);
          fl_len.push_back(ln);
        end
      end
    endcase
    return r;
  endfunction

  // hand one item to the block and record its expected reply
  task automatic send_request(logic [1:0] kind, logic [31:0] blk,
                              logic [31:0] sz, logic [31:0] nsz);
    while ($urandom_range(99) < send_idle) @(posedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {nsz, sz, blk};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    replies_due.push_back(predict_reply(kind, blk, sz, nsz));
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_replies();
    while (replies_due.size() != 0) @(posedge clk);
    repeat (140) @(posedge clk);
  endtask

  task automatic write_arena(logic [31:0] base, logic [31:0] bytes);
    drain_replies();
    cfg_we <= 1'b1;
    cfg_index <= CFG_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_index <= CFG_BYTES;
    cfg_wdata <= bytes;
    @(posedge clk);
    cfg_we <= 1'b0;
    base_q = {1'b0, base};
    bytes_q = {1'b0, bytes};
  endtask

  // accept and compare results
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected result status %0d addr %h", $time,
                   m_axis_tuser, m_axis_tdata);
          errors++;
        end else begin
          if (replies_due[0].status !== m_axis_tuser ||
              replies_due[0].addr !== m_axis_tdata) begin
            $display("%0t: expected status %0d addr %h, got status %0d addr %h",
                     $time, replies_due[0].status, replies_due[0].addr,
                     m_axis_tuser, m_axis_tdata);
            errors++;
          end
          void'(replies_due.pop_front());
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic test_edges();
    write_arena(32'h0000_1000, 32'h0000_0100);
    send_request(KIND_ALLOC, '0, 32'd0, '0);
    send_request(KIND_INIT, '0, '0, '0);
    send_request(KIND_ALLOC, '0, 32'd0, '0);
    send_request(KIND_ALLOC, '0, 32'h10, '0);
    send_request(KIND_ALLOC, '0, 32'h20, '0);
    send_request(KIND_ALLOC, '0, 32'hFFFF_FFFF, '0);
    send_request(KIND_FREE, 32'h1000, 32'h10, '0);
    send_request(KIND_FREE, 32'h1000, 32'd0, '0);
    send_request(KIND_FREE, 32'hFFFF_FFF0, 32'h20, '0);
    send_request(KIND_FREE, 32'h1010, 32'h20, '0);
    send_request(KIND_ALLOC, '0, 32'h40, '0);
    send_request(KIND_RESIZE, 32'h1000, 32'h40, 32'h40);
    send_request(KIND_RESIZE, 32'h1000, 32'h40, 32'h10);
    send_request(KIND_RESIZE, 32'h1000, 32'h10, 32'h50);
    send_request(KIND_RESIZE, 32'h1000, 32'h50, 32'hFFFF_FFFF);
    send_request(KIND_ALLOC, '0, 32'hC0, '0);
    send_request(KIND_ALLOC, '0, 32'h1, '0);
    write_arena(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(KIND_INIT, '0, '0, '0);
    write_arena(32'h0, 32'hFFFF_FFFF);
    send_request(KIND_INIT, '0, '0, '0);
    send_request(KIND_ALLOC, '0, 32'hFFFF_FFFF, '0);
    write_arena(32'hFFFF_0000, 32'h0);
    send_request(KIND_INIT, '0, '0, '0);
  endtask

  // fill the pool with holes so the slot count runs out
  task automatic test_slot_exhaustion();
    write_arena(32'h0, 32'h1000);
    send_request(KIND_INIT, '0, '0, '0);
    send_request(KIND_ALLOC, '0, 32'h1000, '0);
    for (int i = 0; i < PoolNodes + 2; i++)
      send_request(KIND_FREE, i * 32'h20, 32'h10, '0);
    send_request(KIND_FREE, 32'h10, 32'h10, '0);
    send_request(KIND_FREE, 32'h2000, 32'h8, '0);
  endtask

  // random traffic against a small arena, mostly well-formed
  task automatic test_random(int count);
    logic [31:0] live_a[$], live_s[$];
    logic [31:0] a, s, n;
    int          pick, k;
    write_arena($urandom_range(3) == 0 ? $urandom() : $urandom_range(4095) * 16,
                $urandom_range(256, 4096));
    send_request(KIND_INIT, '0, '0, '0);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 40 || live_a.size() == 0) begin
        s = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(1, 200);
        send_request(KIND_ALLOC, $urandom(), s, $urandom());
        if (replies_due[$].status == ST_DONE) begin
          live_a.push_back(replies_due[$].addr);
          live_s.push_back(s);
        end
      end else if (pick < 70) begin
        k = $urandom_range(live_a.size() - 1);
        send_request(KIND_FREE, live_a[k], live_s[k], $urandom());
        live_a.delete(k);
        live_s.delete(k);
      end else if (pick < 90) begin
        k = $urandom_range(live_a.size() - 1);
        n = $urandom_range(3) == 0 ? live_s[k] : $urandom_range(0, 2 * live_s[k] + 64);
        send_request(KIND_RESIZE, live_a[k], live_s[k], n);
        if (replies_due[$].status == ST_DONE) live_s[k] = n;
      end else if (pick < 97) begin
        a = $urandom();
        send_request(KIND_FREE, a, $urandom_range(1) ? $urandom() : $urandom_range(64), '0);
      end else begin
        send_request(pick[0] ? KIND_RESIZE : KIND_INIT, $urandom(), $urandom(), $urandom());
        if (replies_due[$].status == ST_DONE || pick[0] == 1'b0) begin
          live_a.delete();
          live_s.delete();
        end
      end
    end
  endtask

  initial begin
    base_q = '0;
    bytes_q = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    send_idle = 7;
    recv_idle = 81;
    test_edges();
    test_random(120);
    send_idle = 81;
    recv_idle = 7;
    test_slot_exhaustion();
    test_random(120);
    send_idle = 0;
    recv_idle = 0;
    test_random(120);
    drain_replies();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Mismatches found");
    $finish;
  end
endmodule
